// File: design/gwmc_pkg.sv
// ----------------------------------------------------------------------------
// gwmc_pkg
// shared types, constants and helpers of the grid word match counter
// ----------------------------------------------------------------------------
package gwmc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int SYM_W         = 8;
  localparam int GW_W          = 11;
  localparam int COUNT_W       = 23;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 23'd4194304;

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH     = 2'd0,
    CFG_PATTERN_FIRST  = 2'd1,
    CFG_PATTERN_SECOND = 2'd2,
    CFG_PATTERN_THIRD  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SYM_W-1:0] first;
    logic [SYM_W-1:0] second;
    logic [SYM_W-1:0] third;
  } pattern_t;

  // accept-stage request info handed to the match stage
  typedef struct packed {
    logic             col_ge2;
    logic             row_ge2;
    logic             last;
    logic [SYM_W-1:0] sym;
  } req_t;

  function automatic logic [SYM_W-1:0] fold_lower(input logic [SYM_W-1:0] c);
    logic [SYM_W-1:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic [1:0] window_hits(input logic [SYM_W-1:0] a,
                                             input logic [SYM_W-1:0] b,
                                             input logic [SYM_W-1:0] c,
                                             input pattern_t p);
    logic [1:0] h;
    h = 2'd0;
    if (b == p.second) begin
      if (a == p.first && c == p.third) h = h + 2'd1;
      if (c == p.first && a == p.third) h = h + 2'd1;
    end
    return h;
  endfunction

endpackage

// File: design/gwmc_line_buf.sv
// ----------------------------------------------------------------------------
// gwmc_line_buf
// two line buffers in one memory, word = {two rows above, row above}
// ----------------------------------------------------------------------------
module gwmc_line_buf #(
  parameter int MAX_WIDTH = gwmc_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
  output logic [2*gwmc_pkg::SYM_W-1:0]       rd_data,
  input  logic                               wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
  input  logic [2*gwmc_pkg::SYM_W-1:0]       wr_data
);
  import gwmc_pkg::*;

  logic [2*SYM_W-1:0] mem [MAX_WIDTH];
  logic [2*SYM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/gwmc_scan.sv
// ----------------------------------------------------------------------------
// gwmc_scan
// raster position tracking at the accept stage, drives the line buffer read
// ----------------------------------------------------------------------------
module gwmc_scan #(
  parameter int MAX_WIDTH = gwmc_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [gwmc_pkg::GW_W-1:0]         grid_width,
  input  logic [gwmc_pkg::SYM_W-1:0]        symbol,
  input  logic                              grid_end,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output gwmc_pkg::req_t                    req
);
  import gwmc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > GW_W) ? CW + 1 : GW_W;

  logic [CW-1:0] column_index_r, column_index_nxt;
  logic [1:0]    row_index_r, row_index_nxt;
  logic [WW-1:0] width_eff;
  logic [WW-1:0] col_inc;
  logic          wrap;

  always_comb begin
    width_eff = WW'(grid_width);
    if (grid_width == '0) width_eff = WW'(1);
    else if (WW'(grid_width) > WW'(MAX_WIDTH)) width_eff = WW'(MAX_WIDTH);
    col_inc = WW'(column_index_r) + WW'(1);
    wrap    = (col_inc >= width_eff);

    column_index_nxt = column_index_r;
    row_index_nxt    = row_index_r;
    if (accept) begin
      if (grid_end) begin
        column_index_nxt = '0;
        row_index_nxt    = 2'd0;
      end else if (wrap) begin
        column_index_nxt = '0;
        if (row_index_r != 2'd2) row_index_nxt = row_index_r + 2'd1;
      end else begin
        column_index_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_index_r <= '0;
      row_index_r    <= 2'd0;
    end else begin
      column_index_r <= column_index_nxt;
      row_index_r    <= row_index_nxt;
    end
  end

  assign col         = column_index_r;
  assign req.col_ge2 = (WW'(column_index_r) >= WW'(2));
  assign req.row_ge2 = (row_index_r == 2'd2);
  assign req.last    = grid_end;
  assign req.sym     = fold_lower(symbol);

endmodule

// File: design/gwmc_match.sv
// ----------------------------------------------------------------------------
// gwmc_match
// window compare stage, line buffer write-back, running count, result register
// ----------------------------------------------------------------------------
module gwmc_match #(
  parameter int MAX_WIDTH = gwmc_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [$clog2(MAX_WIDTH)-1:0]      in_col,
  input  gwmc_pkg::req_t                    req,
  input  gwmc_pkg::pattern_t                pattern,
  input  logic [2*gwmc_pkg::SYM_W-1:0]      rd_data,
  output logic                              wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
  output logic [2*gwmc_pkg::SYM_W-1:0]      wr_data,
  output logic                              busy,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gwmc_pkg::COUNT_W-1:0]      out_match_count
);
  import gwmc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic               s1_valid_r, s1_valid_nxt;
  req_t               s1_req_r;
  logic [CW-1:0]      s1_col_r;
  logic               fwd_r;
  logic [SYM_W-1:0]   fwd_above_r;
  logic [SYM_W-1:0]   fwd_two_r;
  logic [SYM_W-1:0]   prev0_r, prev0_nxt;
  logic [SYM_W-1:0]   prev1_r, prev1_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r;

  logic               s1_go;
  logic [SYM_W-1:0]   above;
  logic [SYM_W-1:0]   two_above;
  logic [1:0]         h_hits;
  logic [1:0]         v_hits;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] count_sat;

  assign busy  = s1_valid_r && s1_req_r.last && out_valid_r && out_stall;
  assign s1_go = s1_valid_r && !busy;

  always_comb begin
    above     = fwd_r ? fwd_above_r : rd_data[SYM_W-1:0];
    two_above = fwd_r ? fwd_two_r   : rd_data[2*SYM_W-1:SYM_W];
    h_hits    = s1_req_r.col_ge2 ? window_hits(prev1_r, prev0_r, s1_req_r.sym, pattern) : 2'd0;
    v_hits    = s1_req_r.row_ge2 ? window_hits(two_above, above, s1_req_r.sym, pattern)
                                 : 2'd0;
    sum       = {1'b0, count_r} + (COUNT_W+1)'(h_hits) + (COUNT_W+1)'(v_hits);
    count_sat = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];

    s1_valid_nxt = s1_valid_r;
    if (accept) s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;

    prev0_nxt = prev0_r;
    prev1_nxt = prev1_r;
    count_nxt = count_r;
    if (s1_go) begin
      if (s1_req_r.last) begin
        prev0_nxt = '0;
        prev1_nxt = '0;
        count_nxt = '0;
      end else begin
        prev0_nxt = s1_req_r.sym;
        prev1_nxt = prev0_r;
        count_nxt = count_sat;
      end
    end

    out_valid_nxt = out_valid_r;
    if (s1_go && s1_req_r.last) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev0_r     <= '0;
      prev1_r     <= '0;
      count_r     <= '0;
      fwd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      prev0_r     <= prev0_nxt;
      prev1_r     <= prev1_nxt;
      count_r     <= count_nxt;
      if (accept) fwd_r <= s1_go && (s1_col_r == in_col);
    end
  end

  // same column written back while read: take the new word directly
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r    <= req;
      s1_col_r    <= in_col;
      fwd_above_r <= s1_req_r.sym;
      fwd_two_r   <= above;
    end
    if (s1_go && s1_req_r.last) out_count_r <= count_sat;
  end

  assign wr_en           = s1_go;
  assign wr_addr         = s1_col_r;
  assign wr_data         = {above, s1_req_r.sym};
  assign out_valid       = out_valid_r;
  assign out_match_count = out_count_r;

endmodule

// File: design/grid_word_match_counter_top.sv
// ----------------------------------------------------------------------------
// grid_word_match_counter_top
// counts a three-letter pattern in four directions over a streamed grid
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  in       | in_valid/in_stall  | in_symbol[7:0], in_grid_end
//  out      | out_valid/out_stall| out_match_count[22:0]
//  cfg      | cfg_wr_en          | cfg_index[1:0], cfg_data[10:0]
//
//  one request per cycle while in_stall is low; the single line buffer memory
//  port pair (one read at accept, one write from the match stage) sets that rate,
//  same-column hazards forwarded; result registered on the grid_end write-back
//  synchronous active-low reset, no clearing pass (line buffers written before read)
//  in_stall rises only while a finished count waits and out_stall is high
// ----------------------------------------------------------------------------
module grid_word_match_counter_top #(
  parameter int MAX_WIDTH = gwmc_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gwmc_pkg::SYM_W-1:0]        in_symbol,
  input  logic                              in_grid_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gwmc_pkg::COUNT_W-1:0]      out_match_count,
  input  logic                              cfg_wr_en,
  input  logic [gwmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gwmc_pkg::GW_W-1:0]         cfg_data
);
  import gwmc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [GW_W-1:0]    grid_width_r;
  pattern_t           pattern_r;
  logic               accept;
  logic               busy;
  logic [CW-1:0]      col;
  req_t               req;
  logic [2*SYM_W-1:0] rd_data;
  logic               wr_en;
  logic [CW-1:0]      wr_addr;
  logic [2*SYM_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= 11'd1024;
      pattern_r.first  <= 8'd98;
      pattern_r.second <= 8'd117;
      pattern_r.third  <= 8'd103;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:     grid_width_r     <= cfg_data;
        CFG_PATTERN_FIRST:  pattern_r.first  <= cfg_data[SYM_W-1:0];
        CFG_PATTERN_SECOND: pattern_r.second <= cfg_data[SYM_W-1:0];
        CFG_PATTERN_THIRD:  pattern_r.third  <= cfg_data[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  gwmc_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .grid_width (grid_width_r),
    .symbol     (in_symbol),
    .grid_end   (in_grid_end),
    .col        (col),
    .req        (req)
  );

  gwmc_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gwmc_match #(.MAX_WIDTH(MAX_WIDTH)) u_match (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_col          (col),
    .req             (req),
    .pattern         (pattern_r),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_count (out_match_count)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid word match counter testbench
// streams character grids into the counter under random valid and stall
// timing, predicts every grid total in a scoreboard and checks each returned
// count; covers reset defaults, mid-grid width shrink, width clamping,
// palindromic patterns and a long output hold-off
// ----------------------------------------------------------------------------
module testbench;
  import gwmc_pkg::*;

  localparam int MAX_W           = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS    = 1000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 3000;

  class grid_count_board;
    bit [GW_W-1:0]    width_reg;
    bit [SYM_W-1:0]   pat_first;
    bit [SYM_W-1:0]   pat_second;
    bit [SYM_W-1:0]   pat_third;
    int unsigned      col_pos;
    int unsigned      row_pos;
    bit [SYM_W-1:0]   last_sym;
    bit [SYM_W-1:0]   prior_sym;
    bit [SYM_W-1:0]   line_up1 [MAX_W];
    bit [SYM_W-1:0]   line_up2 [MAX_W];
    int unsigned      running;
    bit [COUNT_W-1:0] pending_counts [$];
    int unsigned      errors;

    function new();
      width_reg  = 11'd1024;
      pat_first  = 8'd98;
      pat_second = 8'd117;
      pat_third  = 8'd103;
      errors     = 0;
      clear_grid();
    endfunction

    function void clear_grid();
      col_pos   = 0;
      row_pos   = 0;
      last_sym  = '0;
      prior_sym = '0;
      running   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [GW_W-1:0] value);
      case (idx)
        CFG_GRID_WIDTH:     width_reg  = value;
        CFG_PATTERN_FIRST:  pat_first  = value[SYM_W-1:0];
        CFG_PATTERN_SECOND: pat_second = value[SYM_W-1:0];
        CFG_PATTERN_THIRD:  pat_third  = value[SYM_W-1:0];
        default: ;
      endcase
    endfunction

    // forward and reverse reading of one three-character window
    function int unsigned triple_hits(bit [SYM_W-1:0] a, bit [SYM_W-1:0] b,
                                      bit [SYM_W-1:0] c);
      int unsigned n;
      n = 0;
      if (b == pat_second) begin
        if (a == pat_first && c == pat_third) n++;
        if (c == pat_first && a == pat_third) n++;
      end
      return n;
    endfunction

    function void tally_symbol(bit [SYM_W-1:0] sym, bit last);
      bit [SYM_W-1:0] ch;
      int unsigned    eff_w;
      int unsigned    hits;
      ch = (sym >= 8'h41 && sym <= 8'h5a) ? sym + 8'h20 : sym;
      if (width_reg == 0) eff_w = 1;
      else if (width_reg > MAX_W) eff_w = MAX_W;
      else eff_w = int'(width_reg);
      hits = 0;
      if (col_pos >= 2) hits += triple_hits(prior_sym, last_sym, ch);
      if (row_pos >= 2) hits += triple_hits(line_up2[col_pos], line_up1[col_pos], ch);
      running += hits;
      if (running > COUNT_MAX) running = int'(COUNT_MAX);
      line_up2[col_pos] = line_up1[col_pos];
      line_up1[col_pos] = ch;
      prior_sym = last_sym;
      last_sym  = ch;
      if (col_pos + 1 >= eff_w) begin
        col_pos = 0;
        if (row_pos < 2) row_pos++;
      end else begin
        col_pos++;
      end
      if (last) begin
        pending_counts.insert(pending_counts.size(), COUNT_W'(running));
        clear_grid();
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_count(bit [COUNT_W-1:0] got);
      bit [COUNT_W-1:0] want;
      if (pending_counts.size() == 0) begin
        report($sformatf("count %0d with no grid outstanding", got));
      end else begin
        want = pending_counts.pop_front();
        if (got != want) report($sformatf("match_count %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SYM_W-1:0]     in_symbol = '0;
  logic                 in_grid_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COUNT_W-1:0]   out_match_count;
  logic                 cfg_wr_en = 1'b0;
  cfg_idx_t             cfg_index = CFG_GRID_WIDTH;
  logic [GW_W-1:0]      cfg_data = '0;

  grid_count_board board = new();
  int unsigned     send_gap_max = 11;
  int unsigned     recv_stall_max = 11;
  int unsigned     sent_count = 0;
  int unsigned     idle_cycles = 0;
  logic            hold_off_req = 1'b0;

  grid_word_match_counter_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_symbol       (in_symbol),
    .in_grid_end     (in_grid_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_count (out_match_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_symbol(input bit [SYM_W-1:0] sym, input bit last);
    int unsigned gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_symbol   <= sym;
    in_grid_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.tally_symbol(sym, last);
    sent_count++;
  endtask

  task automatic send_text(input string text, input bit end_grid);
    int i;
    for (i = 0; i < text.len(); i++) begin
      send_symbol(text[i], end_grid && (i == text.len() - 1));
    end
  endtask

  // let the pipeline drain before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input bit [GW_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.set_reg(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_config(input bit [GW_W-1:0] width, input bit [SYM_W-1:0] p1,
                              input bit [SYM_W-1:0] p2, input bit [SYM_W-1:0] p3);
    write_reg(CFG_GRID_WIDTH, width);
    write_reg(CFG_PATTERN_FIRST, {3'b000, p1});
    write_reg(CFG_PATTERN_SECOND, {3'b000, p2});
    write_reg(CFG_PATTERN_THIRD, {3'b000, p3});
  endtask

  function automatic bit [SYM_W-1:0] pick_pattern_char();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 50) return 8'h61 + SYM_W'($urandom_range(4, 0));
    if (roll < 80) return 8'h61 + SYM_W'($urandom_range(25, 0));
    return SYM_W'($urandom_range(255, 0));
  endfunction

  // mostly pattern letters in either case, some other letters, some raw bytes
  function automatic bit [SYM_W-1:0] pick_symbol();
    bit [SYM_W-1:0] s;
    int unsigned    roll;
    roll = $urandom_range(99, 0);
    if (roll < 60) begin
      case ($urandom_range(2, 0))
        0:       s = board.pat_first;
        1:       s = board.pat_second;
        default: s = board.pat_third;
      endcase
    end else if (roll < 85) begin
      s = 8'h61 + SYM_W'($urandom_range(4, 0));
    end else begin
      s = SYM_W'($urandom_range(255, 0));
    end
    if (s >= 8'h61 && s <= 8'h7a && $urandom_range(1, 0) == 1) s = s - 8'h20;
    return s;
  endfunction

  task automatic random_grid(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) send_symbol(pick_symbol(), i == len - 1);
  endtask

  // result side
  initial begin
    int unsigned stall_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_len = HOLD_OFF_CYCLES;
      end else begin
        stall_len = $urandom_range(recv_stall_max, 0);
      end
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_count(out_match_count);
    end
  end

  initial begin
    int unsigned     random_start;
    int unsigned     phase;
    int unsigned     roll;
    bit [GW_W-1:0]   width;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pattern and width, case folding edges, byte extremes
    send_text("BUG@[", 1'b0);
    send_symbol(8'h60, 1'b0);
    send_text("{GUB", 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b1);

    // palindromic pattern, width shrinks in the middle of a grid
    settle();
    write_config(11'd3, 8'h61, 8'h62, 8'h61);
    send_text("ababbbab", 1'b0);
    settle();
    write_reg(CFG_GRID_WIDTH, 11'd2);
    send_text("aba", 1'b1);

    random_start = sent_count;
    phase = 0;
    while (sent_count - random_start < RANDOM_ITEMS) begin
      settle();
      send_gap_max   = (phase % 4 == 3) ? 0 : 11;
      recv_stall_max = (phase % 5 == 4) ? 0 : 11;
      if (phase == 3) begin
        write_config(11'd2, pick_pattern_char(), pick_pattern_char(), pick_pattern_char());
        hold_off_req = 1'b1;
        repeat (30) random_grid($urandom_range(3, 1));
      end else begin
        roll = $urandom_range(9, 0);
        case (roll)
          0:       width = 11'd0;
          1:       width = 11'h7ff;
          2:       width = 11'd1024;
          default: width = GW_W'($urandom_range(12, 1));
        endcase
        write_config(width, pick_pattern_char(), pick_pattern_char(), pick_pattern_char());
        repeat ($urandom_range(4, 1)) random_grid($urandom_range(40, 1));
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (board.pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
design/gwmc_pkg.sv
design/gwmc_line_buf.sv
design/gwmc_scan.sv
design/gwmc_match.sv
design/grid_word_match_counter_top.sv
verif/testbench.sv
